// ===== src/ansi_aware_display_width_macros.svh =====
// assertion helpers for the display width block
`ifndef ANSI_AWARE_DISPLAY_WIDTH_MACROS_SVH
`define ANSI_AWARE_DISPLAY_WIDTH_MACROS_SVH
// implication checked at every edge outside reset
`define ADW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication outside reset
`define ADW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/adw_pkg.sv =====
package adw_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } adw_in_t;

  typedef struct packed {
    logic [15:0] display_width;
    logic        width_saturated;
  } adw_out_t;

  typedef enum logic [2:0] {
    ESC_IDLE  = 3'd0,
    ESC_AFTER = 3'd1,
    ESC_CSI   = 3'd2,
    ESC_OSC   = 3'd3,
    ESC_OSCE  = 3'd4
  } adw_esc_t;

  localparam logic [20:0] CP_ZWJ  = 21'h200D;
  localparam logic [20:0] CP_VS16 = 21'hFE0F;
  localparam logic [20:0] CP_VS15 = 21'hFE0E;
  localparam logic [20:0] RI_LO   = 21'h1F1E6;
  localparam logic [20:0] RI_HI   = 21'h1F1FF;
  localparam logic [16:0] SAT_CAP = 17'h10000;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       take;
  } adw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic out_full;
  } adw_sts_t;

  function automatic logic in_rng(input logic [20:0] cp, input logic [20:0] lo,
                                  input logic [20:0] hi);
    in_rng = (cp >= lo) && (cp <= hi);
  endfunction

  function automatic logic is_base(input logic [20:0] cp);
    is_base = in_rng(cp, 21'h1F300, 21'h1FAFF) || in_rng(cp, 21'h2600, 21'h27BF)
              || in_rng(cp, RI_LO, RI_HI);
  endfunction

  function automatic logic [1:0] cp_cols(input logic [20:0] cp);
    logic wide;
    wide = in_rng(cp, 21'h1100, 21'h115F) || in_rng(cp, 21'h2E80, 21'h9FFF)
           || in_rng(cp, 21'hAC00, 21'hD7AF) || in_rng(cp, 21'hF900, 21'hFAFF)
           || in_rng(cp, 21'hFE10, 21'hFE1F) || in_rng(cp, 21'hFE30, 21'hFE6F)
           || in_rng(cp, 21'hFF00, 21'hFF60) || in_rng(cp, 21'hFFE0, 21'hFFE6)
           || in_rng(cp, 21'h20000, 21'h2FFFF) || in_rng(cp, 21'h1F300, 21'h1FAFF)
           || in_rng(cp, RI_LO, RI_HI);
    if (cp < 21'd32 || cp == 21'd127) begin
      cp_cols = 2'd0;
    end else if (cp < 21'd128) begin
      cp_cols = 2'd1;
    end else if (cp == CP_ZWJ || cp == CP_VS16 || cp == CP_VS15
                 || in_rng(cp, 21'h0300, 21'h036F) || cp == 21'h20E3
                 || in_rng(cp, 21'h1F3FB, 21'h1F3FF)) begin
      cp_cols = 2'd0;
    end else if (wide) begin
      cp_cols = 2'd2;
    end else begin
      cp_cols = 2'd1;
    end
  endfunction

endpackage

// ===== src/adw_ctrl.sv =====
module adw_ctrl
  import adw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  adw_in_t  in_word,
  input  logic     out_stall,
  input  adw_sts_t sts,
  output adw_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_RUN    = 3'b001,
    ST_REPLAY = 3'b010,
    ST_FINISH = 3'b100
  } st_t;

  st_t st_r, st_nxt;
  logic acc;

  // run takes bytes; replay runs while datapath drains held bytes;
  // finish flushes tail after a last word
  assign in_stall = (st_r != ST_RUN) || sts.busy || (in_word.last_byte && sts.out_full);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    cmd.load      = acc;
    cmd.data_byte = in_word.data_byte;
    cmd.last_byte = in_word.last_byte;
    cmd.take      = !out_stall;
    st_nxt        = st_r;
    case (st_r)
      ST_RUN: begin
        if (acc && in_word.last_byte) begin
          st_nxt = ST_FINISH;
        end else if (acc) begin
          st_nxt = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (!sts.busy) begin
          st_nxt = ST_RUN;
        end
      end
      ST_FINISH: begin
        if (!sts.busy) begin
          st_nxt = ST_RUN;
        end
      end
      default: st_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RUN;
    end else begin
      st_r <= st_nxt;
    end
  end

`include "ansi_aware_display_width_macros.svh"
  `ADW_ASSERT_IMP(a_onehot, 1'b1, $onehot(st_r), "state not one-hot")
  `ADW_ASSERT_NEXT(a_last_fin, acc && in_word.last_byte, st_r == ST_FINISH, "no finish")
  `ADW_ASSERT_IMP(a_no_acc, st_r != ST_RUN, !acc, "word taken while busy")

endmodule

// ===== src/adw_dp.sv =====
module adw_dp
  import adw_pkg::*;
#(
  parameter int ESC_MAX_LEN = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  adw_cmd_t cmd,
  output adw_sts_t sts,
  output logic     out_valid,
  output adw_out_t out_word
);

  // work queue of bytes to examine: up to 3 in use (two held + one new)
  logic [7:0] q_r [4];
  logic [7:0] q_nxt [4];
  logic [2:0] qn_r, qn_nxt;
  logic       fin_r, fin_nxt;
  adw_esc_t   esc_r, esc_nxt;
  logic [6:0] elen_r, elen_nxt;
  logic [7:0] pb_r [3];
  logic [7:0] pb_nxt [3];
  logic [1:0] pc_r, pc_nxt;
  logic [2:0] el_r, el_nxt;
  logic       zwj_r, zwj_nxt, ri_r, ri_nxt, end_r, end_nxt;
  logic [1:0] pw_r, pw_nxt;
  logic [16:0] tot_r, tot_nxt;
  logic       ov_r, ov_nxt;
  adw_out_t   ow_r, ow_nxt;

  logic [7:0] b;
  logic       have;
  logic [20:0] cp;
  logic       apply, ok, raw;
  logic [2:0] addw;
  logic [17:0] sum;

  assign sts.busy     = (qn_r != 3'd0) || fin_r;
  assign sts.out_full = ov_r;
  assign out_valid    = ov_r;
  assign out_word     = ow_r;

  always_comb begin
    for (int i = 0; i < 4; i++) q_nxt[i] = q_r[i];
    for (int i = 0; i < 3; i++) pb_nxt[i] = pb_r[i];
    qn_nxt = qn_r; fin_nxt = fin_r; esc_nxt = esc_r; elen_nxt = elen_r;
    pc_nxt = pc_r; el_nxt = el_r; zwj_nxt = zwj_r; ri_nxt = ri_r; end_nxt = end_r;
    pw_nxt = pw_r; tot_nxt = tot_r; ov_nxt = ov_r && !cmd.take; ow_nxt = ow_r;
    apply = 1'b0; cp = '0; ok = 1'b0; raw = 1'b0; addw = '0; sum = '0;
    have = 1'b0; b = q_r[0];
    if (cmd.load) begin
      have = 1'b1; b = cmd.data_byte; fin_nxt = cmd.last_byte;
    end else if (qn_r != 3'd0) begin
      have = 1'b1; b = q_r[0];
      for (int i = 0; i < 3; i++) q_nxt[i] = q_r[i + 1];
      qn_nxt = qn_r - 3'd1;
    end else if (fin_r) begin
      // tail: flush held bytes one at a time, then pending indicator, then emit
      if (pc_r != 2'd0) begin
        apply = 1'b1; cp = {13'd0, pb_r[0]};
        pb_nxt[0] = pb_r[1]; pb_nxt[1] = pb_r[2];
        pc_nxt = pc_r - 2'd1;
        if (pc_r == 2'd1) el_nxt = '0;
      end else if (ri_r) begin
        addw = 3'd2; ri_nxt = 1'b0;
      end else if (!ov_r || cmd.take) begin
        ow_nxt.display_width   = tot_r[16] ? 16'hFFFF : tot_r[15:0];
        ow_nxt.width_saturated = tot_r[16];
        ov_nxt = 1'b1; fin_nxt = 1'b0;
        esc_nxt = ESC_IDLE; elen_nxt = '0; el_nxt = '0; zwj_nxt = 1'b0;
        pw_nxt = '0; tot_nxt = '0; end_nxt = 1'b0;
      end
    end
    if (have && !end_r) begin
      case (esc_r)
        ESC_AFTER: begin
          if (b == 8'h5B) begin
            esc_nxt = ESC_CSI; elen_nxt = 7'd2;
          end else if (b == 8'h5D) begin
            esc_nxt = ESC_OSC; elen_nxt = 7'd2;
          end else begin
            esc_nxt = ESC_IDLE; elen_nxt = '0;
          end
        end
        ESC_CSI: begin
          if (elen_r >= 7'(ESC_MAX_LEN) || b < 8'h20 || b > 8'h7E) begin
            esc_nxt = ESC_IDLE; elen_nxt = '0; raw = 1'b1;
          end else if (b >= 8'h40) begin
            esc_nxt = ESC_IDLE; elen_nxt = '0;
          end else begin
            elen_nxt = elen_r + 7'd1;
          end
        end
        ESC_OSC, ESC_OSCE: begin
          if (esc_r == ESC_OSCE && b == 8'h5C) begin
            esc_nxt = ESC_IDLE; elen_nxt = '0;
          end else if (elen_r >= 7'(ESC_MAX_LEN)) begin
            esc_nxt = ESC_IDLE; elen_nxt = '0; raw = 1'b1;
          end else if (b == 8'h07) begin
            esc_nxt = ESC_IDLE; elen_nxt = '0;
          end else if (b == 8'h1B) begin
            esc_nxt = ESC_OSCE; elen_nxt = elen_r + 7'd1;
          end else begin
            esc_nxt = ESC_OSC; elen_nxt = elen_r + 7'd1;
          end
        end
        default: raw = 1'b1;
      endcase
      // raw: byte examined as text (with pending UTF-8 state)
      if (raw) begin
        if (pc_r != 2'd0) begin
          if (b[7:6] != 2'b10) begin
            // flush first held byte, requeue rest then this byte
            apply = 1'b1; cp = {13'd0, pb_r[0]};
            q_nxt[0] = pb_r[1]; q_nxt[1] = pb_r[2];
            q_nxt[pc_r - 2'd1] = b;
            qn_nxt = 3'(pc_r);
            pc_nxt = '0; el_nxt = '0;
          end else if ({1'b0, pc_r} + 3'd1 < el_r) begin
            pb_nxt[pc_r] = b; pc_nxt = pc_r + 2'd1;
          end else begin
            case (el_r)
              3'd2: begin
                cp = {10'd0, pb_r[0][4:0], b[5:0]}; ok = cp >= 21'h80;
              end
              3'd3: begin
                cp = {5'd0, pb_r[0][3:0], pb_r[1][5:0], b[5:0]};
                ok = cp >= 21'h800 && !in_rng(cp, 21'hD800, 21'hDFFF);
              end
              default: begin
                cp = {pb_r[0][2:0], pb_r[1][5:0], pb_r[2][5:0], b[5:0]};
                ok = cp >= 21'h10000 && cp <= 21'h10FFFF;
              end
            endcase
            apply = 1'b1;
            if (ok) begin
              pc_nxt = '0; el_nxt = '0;
            end else begin
              // lead flushed now; other held bytes and this one count as raw
              cp = {13'd0, pb_r[0]};
              q_nxt[0] = pb_r[1]; q_nxt[1] = pb_r[2];
              q_nxt[pc_r - 2'd1] = b;
              qn_nxt = 3'(pc_r);
              pc_nxt = '0; el_nxt = '0;
            end
          end
        end else if (b == 8'h00) begin
          end_nxt = 1'b1;
        end else if (b == 8'h1B) begin
          esc_nxt = ESC_AFTER; elen_nxt = 7'd1;
        end else if (b[7] == 1'b0) begin
          apply = 1'b1; cp = {13'd0, b};
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
          el_nxt = (b[7:5] == 3'b110) ? 3'd2 : (b[7:4] == 4'b1110) ? 3'd3 : 3'd4;
          pb_nxt[0] = b; pc_nxt = 2'd1;
        end else begin
          apply = 1'b1; cp = {13'd0, b};
        end
      end
    end
    if (apply) begin
      if (cp == CP_ZWJ) begin
        zwj_nxt = 1'b1;
      end else if (cp == CP_VS16) begin
        if (pw_r == 2'd1) addw = 3'd1;
      end else if (cp == CP_VS15) begin
        addw = 3'd0;
      end else if (in_rng(cp, RI_LO, RI_HI)) begin
        if (ri_r) addw = 3'd2;
        ri_nxt = !ri_r; pw_nxt = '0;
      end else begin
        if (ri_r) begin
          addw = 3'd2; ri_nxt = 1'b0;
        end
        zwj_nxt = 1'b0;
        if (zwj_r && is_base(cp)) begin
          pw_nxt = '0;
        end else begin
          addw = addw + {1'b0, cp_cols(cp)};
          pw_nxt = cp_cols(cp);
        end
      end
    end
    if (addw != 3'd0) begin
      sum = {1'b0, tot_r} + {15'd0, addw};
      tot_nxt = (sum > {1'b0, SAT_CAP}) ? SAT_CAP : sum[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qn_r <= '0; fin_r <= 1'b0; esc_r <= ESC_IDLE; elen_r <= '0; pc_r <= '0;
      el_r <= '0; zwj_r <= 1'b0; ri_r <= 1'b0; end_r <= 1'b0; pw_r <= '0;
      tot_r <= '0; ov_r <= 1'b0;
    end else begin
      qn_r <= qn_nxt; fin_r <= fin_nxt; esc_r <= esc_nxt; elen_r <= elen_nxt;
      pc_r <= pc_nxt; el_r <= el_nxt; zwj_r <= zwj_nxt; ri_r <= ri_nxt;
      end_r <= end_nxt; pw_r <= pw_nxt; tot_r <= tot_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) q_r[i] <= q_nxt[i];
    for (int i = 0; i < 3; i++) pb_r[i] <= pb_nxt[i];
    ow_r <= ow_nxt;
  end

`include "ansi_aware_display_width_macros.svh"
  `ADW_ASSERT_IMP(a_sat, 1'b1, tot_r <= SAT_CAP, "total beyond cap")
  `ADW_ASSERT_IMP(a_pc, 1'b1, {1'b0, pc_r} < 3'd4, "held count out of range")
  `ADW_ASSERT_NEXT(a_hold, ov_r && !cmd.take, ov_r && $stable(ow_r), "result lost")

endmodule

// ===== src/ansi_aware_display_width.sv =====
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_word (data_byte, last_byte)
// out     | output    | out_valid, out_stall, out_word (display_width, width_saturated)
// an ordinary byte is examined when it is taken, then the controller passes through replay before taking another
// a bad utf-8 sequence replays its other held bytes and the breaking byte through the decoder one at a time
// a last byte is followed by a flush of held bytes one at a time, then a lone indicator, then the emit
// synchronous active-low reset clears all control state
// the result register holds while out_stall is high; a new last byte waits for it
module ansi_aware_display_width
  import adw_pkg::*;
#(
  parameter int ESC_MAX_LEN = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  adw_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output adw_out_t out_word
);

  adw_cmd_t cmd;
  adw_sts_t sts;

  adw_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_word, .out_stall, .sts, .cmd
  );

  adw_dp #(.ESC_MAX_LEN(ESC_MAX_LEN)) u_dp (
    .clk, .rst_n, .cmd, .sts, .out_valid, .out_word
  );

endmodule
